### rtl/multibyte_delimiter_tokenizer_unit_defines.svh
// Assertion macros used by the tokenizer unit to check its own logic.
`ifndef MULTIBYTE_DELIMITER_TOKENIZER_UNIT_DEFINES_SVH
`define MULTIBYTE_DELIMITER_TOKENIZER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MDT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MDT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/mdt_pkg.sv
package mdt_pkg;

    // Delimiter window and buffer limits.
    localparam int MAX_DELIMITER_BYTES = 8;
    localparam int BUFFER_BYTES        = 4096;

    localparam int BYTE_W  = 8;
    localparam int DELIM_W = MAX_DELIMITER_BYTES * BYTE_W;
    localparam int LEN_W   = 4;
    localparam int SEL_W   = $clog2(MAX_DELIMITER_BYTES);
    localparam int POS_W   = $clog2(BUFFER_BYTES) + 1;
    localparam int OFS_W   = $clog2(BUFFER_BYTES);
    localparam int CFG_IDX_W = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DELIM_BYTES  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELIM_LENGTH = 4'd1;

    // Token status codes.
    localparam logic STATUS_FOUND = 1'b0;
    localparam logic STATUS_NONE  = 1'b1;

    localparam logic [DELIM_W-1:0] DELIM_BYTES_RESET  = 64'd44;
    localparam logic [LEN_W-1:0]   DELIM_LENGTH_RESET = 4'd1;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
    } in_beat_t;

    typedef struct packed {
        logic [OFS_W-1:0] token_offset;
        logic [POS_W-1:0] token_length;
        logic             token_status;
        logic             is_final;
    } out_beat_t;

    // Per-cycle control handed to every window cell.
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

endpackage

### rtl/mdt_cell.sv
// One byte of the comparison window: holds a byte, passes it on, and
// compares the byte entering it with its expected delimiter character.
module mdt_cell
    import mdt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cell_ctrl_t        ctrl,
    input  logic [BYTE_W-1:0] byte_in,
    input  logic [BYTE_W-1:0] want_byte,
    output logic [BYTE_W-1:0] byte_out,
    output logic              hit
);

    logic [BYTE_W-1:0] byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= '0;
        end
        else if (ctrl.clear)
        begin
            byte_reg <= '0;
        end
        else if (ctrl.shift)
        begin
            byte_reg <= byte_in;
        end
    end

    assign hit      = (byte_in == want_byte);
    assign byte_out = byte_reg;

endmodule

### rtl/multibyte_delimiter_tokenizer_unit.sv
// Splits a byte stream at a configurable delimiter string of one to eight
// bytes and reports each non-empty token by offset and length. The block
// takes one byte per clock cycle unless stalled: the match is decided in the
// same cycle by a row of eight window cells, each comparing the byte
// entering it with its delimiter character, and the result is held in a
// single output register, so the input only stalls while a result waits
// there and the output side is stalled. A result appears on the output in the
// cycle after the byte that causes it. Matches are leftmost first and never
// overlap; leading delimiters and runs of delimiters give no empty tokens.
// When the last byte closes no token, a beat with the no-token status and
// is_final set ends the buffer. Bytes past the buffer limit are dropped,
// and the last byte then only closes the buffer. Configuration is written
// through its own port, which is always ready; a write takes effect from the
// next byte, and writes to an unknown index are ignored.
`include "multibyte_delimiter_tokenizer_unit_defines.svh"

module multibyte_delimiter_tokenizer_unit
    import mdt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_beat_t             in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_beat_t            out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DELIM_W-1:0]   cfg_data
);

    // Configuration registers.
    logic [DELIM_W-1:0] delim_reg;
    logic [LEN_W-1:0]   len_reg;

    // Per-buffer state.
    logic [POS_W-1:0] pos_reg;
    logic [OFS_W-1:0] start_reg;
    logic             inside_reg;
    logic [SEL_W-1:0] blackout_reg;
    logic [LEN_W-1:0] win_reg;

    // Output register.
    logic      out_valid_reg;
    out_beat_t out_reg;

    logic [LEN_W-1:0] eff_len;
    logic [LEN_W-1:0] win_inc;
    logic             in_fire;
    logic             overflow;
    logic             take;
    logic             matched;
    logic             emit;
    out_beat_t        result;
    logic [POS_W-1:0] pos_p1;
    logic [POS_W-1:0] mstart;
    logic [POS_W-1:0] start_ext;
    logic [OFS_W-1:0] open_start;
    cell_ctrl_t       cell_ctrl;

    logic [BYTE_W-1:0]              cell_in   [MAX_DELIMITER_BYTES];
    logic [BYTE_W-1:0]              cell_q    [MAX_DELIMITER_BYTES-1];
    logic [BYTE_W-1:0]              want      [MAX_DELIMITER_BYTES];
    logic [MAX_DELIMITER_BYTES-1:0] hit;
    logic [MAX_DELIMITER_BYTES-1:0] in_use;

    // The configuration port never pushes back.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_reg <= DELIM_BYTES_RESET;
            len_reg   <= DELIM_LENGTH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_DELIM_BYTES:  delim_reg <= cfg_data;
                CFG_DELIM_LENGTH: len_reg   <= cfg_data[LEN_W-1:0];
                default:          ;
            endcase
        end
    end

    // Lengths above the window size behave as the full window.
    assign eff_len = (len_reg > LEN_W'(MAX_DELIMITER_BYTES)) ?
                     LEN_W'(MAX_DELIMITER_BYTES) : len_reg;

    // A new byte enters while the output register is free or being emptied.
    assign in_stall = out_valid_reg && out_stall;
    assign in_fire  = in_valid && !in_stall;
    assign overflow = (pos_reg >= POS_W'(BUFFER_BYTES));
    assign take     = in_fire && !overflow;

    assign cell_ctrl.shift = take;
    assign cell_ctrl.clear = in_fire && in_data.last_byte;

    // Cell j sees the byte that will be j places back after this shift and
    // compares it against delimiter character eff_len-1-j.
    always_comb
    begin
        logic [LEN_W-1:0] sel;
        sel = '0;
        for (int j = 0; j < MAX_DELIMITER_BYTES; j++)
        begin
            sel       = eff_len - LEN_W'(1) - LEN_W'(j);
            in_use[j] = (LEN_W'(j) < eff_len);
            want[j]   = delim_reg[BYTE_W * sel[SEL_W-1:0] +: BYTE_W];
            cell_in[j] = (j == 0) ? in_data.data_byte : cell_q[(j == 0) ? 0 : j - 1];
        end
    end

    for (genvar j = 0; j < MAX_DELIMITER_BYTES; j++)
    begin : g_cell
        if (j == MAX_DELIMITER_BYTES - 1)
        begin : g_tail
            mdt_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (cell_ctrl),
                .byte_in   (cell_in[j]),
                .want_byte (want[j]),
                .byte_out  (),
                .hit       (hit[j])
            );
        end
        else
        begin : g_body
            mdt_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (cell_ctrl),
                .byte_in   (cell_in[j]),
                .want_byte (want[j]),
                .byte_out  (cell_q[j]),
                .hit       (hit[j])
            );
        end
    end

    // Window fill count after this byte, saturating at the window size.
    assign win_inc = (win_reg < LEN_W'(MAX_DELIMITER_BYTES)) ?
                     win_reg + LEN_W'(1) : win_reg;

    // A match needs a quiet blackout, a nonzero length, enough bytes in the
    // window, and every cell in use reporting equality.
    assign matched = (blackout_reg == '0) && (eff_len != '0) &&
                     (win_inc >= eff_len) && (&(hit | ~in_use));

    assign pos_p1     = pos_reg + POS_W'(1);
    assign mstart     = pos_p1 - POS_W'(eff_len);
    assign start_ext  = {1'b0, start_reg};
    assign open_start = inside_reg ? start_reg : pos_reg[OFS_W-1:0];

    always_comb
    begin
        result = '0;
        emit   = 1'b0;
        if (overflow)
        begin
            // Past the limit only the last byte matters; it closes the buffer.
            if (in_data.last_byte)
            begin
                emit            = 1'b1;
                result.is_final = 1'b1;
                if (inside_reg)
                begin
                    result.token_offset = start_reg;
                    result.token_length = POS_W'(BUFFER_BYTES) - start_ext;
                    result.token_status = STATUS_FOUND;
                end
                else
                begin
                    result.token_status = STATUS_NONE;
                end
            end
        end
        else if (matched)
        begin
            // The delimiter closes the open token if anything precedes it.
            if (inside_reg && (mstart > start_ext))
            begin
                emit                = 1'b1;
                result.token_offset = start_reg;
                result.token_length = mstart - start_ext;
                result.token_status = STATUS_FOUND;
                result.is_final     = in_data.last_byte;
            end
            else if (in_data.last_byte)
            begin
                emit                = 1'b1;
                result.token_status = STATUS_NONE;
                result.is_final     = 1'b1;
            end
        end
        else if (in_data.last_byte)
        begin
            emit                = 1'b1;
            result.token_offset = open_start;
            result.token_length = pos_p1 - {1'b0, open_start};
            result.token_status = STATUS_FOUND;
            result.is_final     = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            start_reg    <= '0;
            inside_reg   <= 1'b0;
            blackout_reg <= '0;
            win_reg      <= '0;
        end
        else if (in_fire && in_data.last_byte)
        begin
            // Every buffer starts from a clean state.
            pos_reg      <= '0;
            start_reg    <= '0;
            inside_reg   <= 1'b0;
            blackout_reg <= '0;
            win_reg      <= '0;
        end
        else if (take)
        begin
            pos_reg <= pos_p1;
            win_reg <= win_inc;
            if (blackout_reg != '0)
            begin
                blackout_reg <= blackout_reg - SEL_W'(1);
            end
            if (matched)
            begin
                inside_reg   <= 1'b0;
                blackout_reg <= SEL_W'(eff_len - LEN_W'(1));
            end
            else if (!inside_reg)
            begin
                start_reg  <= pos_reg[OFS_W-1:0];
                inside_reg <= 1'b1;
            end
        end
    end

    // Output register: loaded by a byte that gives a result, emptied when
    // the downstream side takes the beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && emit)
        begin
            out_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `MDT_ASSERT_NOW(a_hold_blocks_input, clk, rst_n,
        out_valid_reg && out_stall, in_stall,
        "input accepted while a result is held")
    `MDT_ASSERT_NEXT(a_last_clears_state, clk, rst_n,
        in_fire && in_data.last_byte,
        (pos_reg == '0) && !inside_reg && (blackout_reg == '0) && (win_reg == '0),
        "buffer state not cleared after the last byte")
    `MDT_ASSERT_NOW(a_blackout_no_match, clk, rst_n,
        blackout_reg != '0, !matched,
        "delimiter match during blackout")
    `MDT_ASSERT_NOW(a_no_token_beat, clk, rst_n,
        out_valid_reg && (out_reg.token_status == STATUS_NONE),
        (out_reg.token_offset == '0) && (out_reg.token_length == '0) && out_reg.is_final,
        "malformed no-token beat")

endmodule
